// ----- design/ibpd_pkg.sv -----
package ibpd_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int ADC_MAX       = (1 << SAMPLE_BITS) - 1;
    localparam int THR_RESET     = 1300;
    localparam int TALLY_LIMIT   = 255;
    localparam int TICK_BITS     = 16;
    localparam int TALLY_BITS    = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int PROD_BITS     = 2 * SAMPLE_BITS;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [1:0] {
        OP_RX   = 2'd0,
        OP_TICK = 2'd1,
        OP_POT  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ON_MARGIN     = 3'd0,
        CFG_OFF_MARGIN    = 3'd1,
        CFG_CONFIRM_COUNT = 3'd2,
        CFG_LOST_TIMEOUT  = 3'd3,
        CFG_THRESHOLD_MIN = 3'd4,
        CFG_THRESHOLD_MAX = 3'd5,
        CFG_ACTIVE_HIGH   = 3'd6,
        CFG_DARK_ON       = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_sample                 on_margin;
        t_sample                 off_margin;
        logic [TALLY_BITS-1:0]   confirm_count;
        logic [TICK_BITS-1:0]    lost_timeout;
        t_sample                 threshold_min;
        t_sample                 threshold_max;
        logic                    active_high;
        logic                    dark_on;
    } t_cfg;

    typedef struct packed {
        t_op     op;
        t_sample sample;
        t_sample target;
    } t_map_item;

endpackage

// ----- design/ibpd_in_if.sv -----
interface ibpd_in_if import ibpd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] op;
    t_sample    sample_value;

    modport source (output valid, output op, output sample_value, input ready);
    modport sink   (input valid, input op, input sample_value, output ready);
endinterface

// ----- design/ibpd_out_if.sv -----
interface ibpd_out_if import ibpd_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    switch_active;
    logic    light_present;
    logic    inside_pulse;
    logic    pulse_counted;
    t_sample current_threshold;

    modport source (output valid, output switch_active, output light_present,
                    output inside_pulse, output pulse_counted, output current_threshold,
                    input ready);
    modport sink   (input valid, input switch_active, input light_present,
                    input inside_pulse, input pulse_counted, input current_threshold,
                    output ready);
endinterface

// ----- design/ibpd_cfg_regs.sv -----
module ibpd_cfg_regs import ibpd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_margin     <= SAMPLE_BITS'(100);
            r_cfg.off_margin    <= SAMPLE_BITS'(100);
            r_cfg.confirm_count <= TALLY_BITS'(2);
            r_cfg.lost_timeout  <= TICK_BITS'(500);
            r_cfg.threshold_min <= SAMPLE_BITS'(800);
            r_cfg.threshold_max <= SAMPLE_BITS'(3200);
            r_cfg.active_high   <= 1'b1;
            r_cfg.dark_on       <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ON_MARGIN:     r_cfg.on_margin     <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_OFF_MARGIN:    r_cfg.off_margin    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_CONFIRM_COUNT: r_cfg.confirm_count <= i_cfg_data[TALLY_BITS-1:0];
                CFG_LOST_TIMEOUT:  r_cfg.lost_timeout  <= i_cfg_data[TICK_BITS-1:0];
                CFG_THRESHOLD_MIN: r_cfg.threshold_min <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_THRESHOLD_MAX: r_cfg.threshold_max <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_ACTIVE_HIGH:   r_cfg.active_high   <= i_cfg_data[0];
                CFG_DARK_ON:       r_cfg.dark_on       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/ibpd_thr_map.sv -----
module ibpd_thr_map import ibpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  t_sample    i_sample,
    input  t_cfg       i_cfg,
    output logic       o_valid,
    input  logic       i_ready,
    output t_map_item  o_item
);

    logic                 r_a_valid;
    t_op                  r_a_op;
    t_sample              r_a_sample;
    logic                 r_b_valid;
    t_op                  r_b_op;
    t_sample              r_b_sample;
    logic [PROD_BITS-1:0] r_b_prod;
    logic                 r_b_neg;
    logic                 r_c_valid;
    t_map_item            r_c_item;

    logic                 a_ready, b_ready, c_ready;
    logic                 span_neg;
    t_sample              span_mag;
    logic [PROD_BITS-1:0] prod;
    t_sample              q0, quot, target;
    logic [SAMPLE_BITS:0] rem;

    assign c_ready = !r_c_valid || i_ready;
    assign b_ready = !r_b_valid || c_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // signed span as sign and magnitude, product of magnitudes
    assign span_neg = i_cfg.threshold_max < i_cfg.threshold_min;
    assign span_mag = span_neg ? i_cfg.threshold_min - i_cfg.threshold_max
                               : i_cfg.threshold_max - i_cfg.threshold_min;
    assign prod     = PROD_BITS'(r_a_sample) * PROD_BITS'(span_mag);

    // divide by full scale: x = q0*2^n + lo = q0*(2^n-1) + (q0 + lo), one correction
    assign q0     = r_b_prod[PROD_BITS-1:SAMPLE_BITS];
    assign rem    = {1'b0, r_b_prod[SAMPLE_BITS-1:0]} + {1'b0, q0};
    assign quot   = q0 + SAMPLE_BITS'(rem >= (SAMPLE_BITS+1)'(ADC_MAX));
    assign target = r_b_neg ? i_cfg.threshold_min - quot : i_cfg.threshold_min + quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) r_a_valid <= i_valid;
            if (b_ready) r_b_valid <= r_a_valid;
            if (c_ready) r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_op     <= t_op'(i_op);
            r_a_sample <= i_sample;
        end
        if (b_ready) begin
            r_b_op     <= r_a_op;
            r_b_sample <= r_a_sample;
            r_b_prod   <= prod;
            r_b_neg    <= span_neg;
        end
        if (c_ready) begin
            r_c_item.op     <= r_b_op;
            r_c_item.sample <= r_b_sample;
            r_c_item.target <= target;
        end
    end

    assign o_valid = r_c_valid;
    assign o_item  = r_c_item;

endmodule

// ----- design/ibpd_core.sv -----
module ibpd_core import ibpd_pkg::*; #(
    parameter int FILTER_SHIFT = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_map_item i_item,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    input  logic      i_ready,
    output logic      o_switch_active,
    output logic      o_light_present,
    output logic      o_inside_pulse,
    output logic      o_pulse_counted,
    output t_sample   o_current_threshold
);

    localparam int ACC_BITS = SAMPLE_BITS + FILTER_SHIFT;

    logic [TICK_BITS-1:0]  r_tick, n_tick;
    logic [TICK_BITS-1:0]  r_stamp, n_stamp;
    logic [TALLY_BITS-1:0] r_tally, n_tally;
    logic                  r_pulse, n_pulse;
    logic                  r_light, n_light;
    t_sample               r_thr, n_thr;
    logic [ACC_BITS-1:0]   r_acc, n_acc;
    logic                  r_loaded, n_loaded;
    logic                  n_counted;
    logic                  r_out_valid;
    logic                  r_out_switch, r_out_light, r_out_pulse, r_out_counted;
    t_sample               r_out_thr;

    logic                  fire;
    logic [SAMPLE_BITS:0]  up_on_sum, up_off_sum;
    t_sample               up_on, up_off, down_on, down_off;
    logic                  enter, leave;
    logic [TALLY_BITS-1:0] tally_inc;
    logic [TICK_BITS-1:0]  tick_inc, since;
    logic [ACC_BITS-1:0]   acc_iir;
    t_sample               filt;

    assign o_ready = !r_out_valid || i_ready;
    assign fire    = i_valid && o_ready;

    // hysteresis bounds, high side saturated, low side floored
    assign up_on_sum  = {1'b0, r_thr} + {1'b0, i_cfg.on_margin};
    assign up_off_sum = {1'b0, r_thr} + {1'b0, i_cfg.off_margin};
    assign up_on      = up_on_sum[SAMPLE_BITS] ? SAMPLE_BITS'(ADC_MAX) : up_on_sum[SAMPLE_BITS-1:0];
    assign up_off     = up_off_sum[SAMPLE_BITS] ? SAMPLE_BITS'(ADC_MAX)
                                                : up_off_sum[SAMPLE_BITS-1:0];
    assign down_on    = (r_thr > i_cfg.on_margin) ? r_thr - i_cfg.on_margin : '0;
    assign down_off   = (r_thr > i_cfg.off_margin) ? r_thr - i_cfg.off_margin : '0;

    assign enter = i_cfg.active_high ? (i_item.sample >= up_on) : (i_item.sample <= down_on);
    assign leave = i_cfg.active_high ? (i_item.sample <= down_off) : (i_item.sample >= up_off);

    assign tally_inc = (r_tally < TALLY_BITS'(TALLY_LIMIT)) ? r_tally + 1'b1 : r_tally;
    assign tick_inc  = r_tick + 1'b1;
    assign since     = tick_inc - r_stamp;

    assign acc_iir = r_acc - (r_acc >> FILTER_SHIFT) + ACC_BITS'(i_item.target);
    assign filt    = acc_iir[ACC_BITS-1:FILTER_SHIFT];

    always_comb begin
        n_tick    = r_tick;
        n_stamp   = r_stamp;
        n_tally   = r_tally;
        n_pulse   = r_pulse;
        n_light   = r_light;
        n_thr     = r_thr;
        n_acc     = r_acc;
        n_loaded  = r_loaded;
        n_counted = 1'b0;
        if (fire) begin
            case (i_item.op)
                OP_RX: begin
                    if (!r_pulse) begin
                        if (enter) begin
                            n_pulse   = 1'b1;
                            n_stamp   = r_tick;
                            n_tally   = tally_inc;
                            n_counted = 1'b1;
                            if (tally_inc >= i_cfg.confirm_count) n_light = 1'b1;
                        end
                    end else if (leave) begin
                        n_pulse = 1'b0;
                    end
                end
                OP_TICK: begin
                    n_tick = tick_inc;
                    if (since >= i_cfg.lost_timeout) begin
                        n_tally = '0;
                        n_pulse = 1'b0;
                        n_light = 1'b0;
                    end
                end
                OP_POT: begin
                    if (!r_loaded) begin
                        n_loaded = 1'b1;
                        n_acc    = {i_item.target, {FILTER_SHIFT{1'b0}}};
                        n_thr    = i_item.target;
                    end else begin
                        n_acc = acc_iir;
                        if (filt < i_cfg.threshold_min) begin
                            n_thr = i_cfg.threshold_min;
                        end else if (filt > i_cfg.threshold_max) begin
                            n_thr = i_cfg.threshold_max;
                        end else begin
                            n_thr = filt;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick      <= '0;
            r_stamp     <= '0;
            r_tally     <= '0;
            r_pulse     <= 1'b0;
            r_light     <= 1'b0;
            r_thr       <= SAMPLE_BITS'(THR_RESET);
            r_acc       <= ACC_BITS'(THR_RESET << FILTER_SHIFT);
            r_loaded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tick   <= n_tick;
            r_stamp  <= n_stamp;
            r_tally  <= n_tally;
            r_pulse  <= n_pulse;
            r_light  <= n_light;
            r_thr    <= n_thr;
            r_acc    <= n_acc;
            r_loaded <= n_loaded;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_switch  <= n_light ^ i_cfg.dark_on;
            r_out_light   <= n_light;
            r_out_pulse   <= n_pulse;
            r_out_counted <= n_counted;
            r_out_thr     <= n_thr;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_switch_active     = r_out_switch;
    assign o_light_present     = r_out_light;
    assign o_inside_pulse      = r_out_pulse;
    assign o_pulse_counted     = r_out_counted;
    assign o_current_threshold = r_out_thr;

endmodule

// ----- design/ir_beam_pulse_detector.sv -----
// channel   dir  handshake      payload
// i_in      in   valid/ready    op, sample_value
// o_out     out  valid/ready    switch_active, light_present, inside_pulse,
//                               pulse_counted, current_threshold
// i_cfg_*   in   write enable   register index, write data
//
// one transaction per cycle sustained while o_out is not stalled, result registered at each stage
// stages: input register, threshold map product, divide and offset, state update
// synchronous active-low reset restores all state, no clearing pass
// a stalled result holds its register, earlier stages keep filling behind it
module ir_beam_pulse_detector import ibpd_pkg::*; #(
    parameter int FILTER_SHIFT = 3
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    ibpd_in_if.sink                  i_in,
    ibpd_out_if.source               o_out
);

    t_cfg      cfg;
    logic      map_valid, map_ready;
    t_map_item map_item;

    ibpd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ibpd_thr_map u_thr_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_op     (i_in.op),
        .i_sample (i_in.sample_value),
        .i_cfg    (cfg),
        .o_valid  (map_valid),
        .i_ready  (map_ready),
        .o_item   (map_item)
    );

    ibpd_core #(
        .FILTER_SHIFT (FILTER_SHIFT)
    ) u_core (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (map_valid),
        .o_ready             (map_ready),
        .i_item              (map_item),
        .i_cfg               (cfg),
        .o_valid             (o_out.valid),
        .i_ready             (o_out.ready),
        .o_switch_active     (o_out.switch_active),
        .o_light_present     (o_out.light_present),
        .o_inside_pulse      (o_out.inside_pulse),
        .o_pulse_counted     (o_out.pulse_counted),
        .o_current_threshold (o_out.current_threshold)
    );

endmodule

// ----- design/ibpd_checker.sv -----
module ibpd_checker import ibpd_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input logic    i_switch_active,
    input logic    i_light_present,
    input logic    i_inside_pulse,
    input logic    i_pulse_counted,
    input t_sample i_current_threshold
);

    // a counted pulse always leaves the detector inside that pulse
    a_counted_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_pulse_counted) |-> i_inside_pulse)
        else $error("pulse counted while not inside pulse");

    // with the result register empty every stage can take a transaction
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid && !i_in_valid) |-> i_in_ready)
        else $error("input stalled with empty pipeline");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_switch_active) && $stable(i_light_present) &&
             $stable(i_inside_pulse) && $stable(i_pulse_counted) &&
             $stable(i_current_threshold)))
        else $error("stalled result dropped or changed");

endmodule

bind ir_beam_pulse_detector ibpd_checker u_ibpd_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_switch_active     (o_out.switch_active),
    .i_light_present     (o_out.light_present),
    .i_inside_pulse      (o_out.inside_pulse),
    .i_pulse_counted     (o_out.pulse_counted),
    .i_current_threshold (o_out.current_threshold)
);
